// File: design/grm_pkg.sv
`timescale 1ns / 1ps
// Shared constants, item and control types of the graph reachability marker.
package grm_pkg;

    // Graph size
    localparam int NODE_COUNT  = 1024;
    localparam int CHILD_SLOTS = 8;

    // Field widths of the items
    localparam int CMD_W   = 3;
    localparam int NODE_W  = 10;
    localparam int SLOT_W  = 3;
    localparam int COUNT_W = 11;

    // Derived storage widths
    localparam int TBL_DEPTH = NODE_COUNT * CHILD_SLOTS;
    localparam int TBL_AW    = $clog2(TBL_DEPTH);
    localparam int VIS_AW    = $clog2(NODE_COUNT);
    localparam int TSLOT_W   = $clog2(CHILD_SLOTS + 1);  // next slot, may reach CHILD_SLOTS
    localparam int DEPTH_W   = $clog2(NODE_COUNT + 1);

    // Command codes
    localparam logic [CMD_W-1:0] CMD_WRITE = 3'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd1;
    localparam logic [CMD_W-1:0] CMD_MARK  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_READ  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_MERGE = 3'd4;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [NODE_W-1:0] node_id;
        logic [SLOT_W-1:0] slot_index;
        logic [NODE_W-1:0] child_id;
        logic              merge_bit;
    } t_in_item;

    typedef struct packed {
        logic               visited_bit;
        logic [COUNT_W-1:0] newly_marked;
    } t_out_item;

    // One walk stack entry: node and the next slot to scan
    typedef struct packed {
        logic [NODE_W-1:0]  node;
        logic [TSLOT_W-1:0] slot;
    } t_stk_entry;

    // Datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SWEEP_ALL,
        OP_SWEEP_VIS,
        OP_LOOK,
        OP_WRITE,
        OP_LOOK_RES,
        OP_ROOT,
        OP_FETCH,
        OP_CHILD,
        OP_VISIT,
        OP_POP,
        OP_POP_LOAD,
        OP_RESULT
    } t_dp_op;

    // Datapath status seen by the controller
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             node_ok;
        logic             sweep_all_last;
        logic             sweep_vis_last;
        logic             slot_end;
        logic             child_zero;
        logic             child_ok;
        logic             depth_one;
    } t_dp_stat;

    function automatic logic [TBL_AW-1:0] tbl_addr(input logic [NODE_W-1:0]  node,
                                                   input logic [TSLOT_W-1:0] slot);
        tbl_addr = TBL_AW'(32'(node) * CHILD_SLOTS + 32'(slot));
    endfunction

endpackage

// File: design/grm_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine of the graph reachability marker.
module grm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    input  grm_pkg::t_dp_stat i_stat,
    output grm_pkg::t_dp_op   o_op
);

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_START,
        S_CLEAR,
        S_LOOK_RES,
        S_ROOT,
        S_FETCH,
        S_CHILD,
        S_VISIT,
        S_POP_LOAD,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_op        = grm_pkg::OP_NONE;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_INIT: begin
                o_op = grm_pkg::OP_SWEEP_ALL;
                if (i_stat.sweep_all_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_op    = grm_pkg::OP_LOAD;
                    n_state = S_START;
                end
            end
            S_START: begin
                if (!i_stat.node_ok) begin
                    n_state = S_DONE;
                end else begin
                    unique case (i_stat.cmd)
                        grm_pkg::CMD_WRITE: begin
                            o_op    = grm_pkg::OP_WRITE;
                            n_state = S_LOOK_RES;
                        end
                        grm_pkg::CMD_CLEAR: begin
                            n_state = S_CLEAR;
                        end
                        grm_pkg::CMD_MARK: begin
                            o_op    = grm_pkg::OP_LOOK;
                            n_state = S_ROOT;
                        end
                        default: begin
                            // read, merge and unknown codes look up the bit; a merge may also set it
                            o_op    = grm_pkg::OP_LOOK;
                            n_state = S_LOOK_RES;
                        end
                    endcase
                end
            end
            S_CLEAR: begin
                o_op = grm_pkg::OP_SWEEP_VIS;
                if (i_stat.sweep_vis_last) begin
                    n_state = S_DONE;
                end
            end
            S_LOOK_RES: begin
                o_op    = grm_pkg::OP_LOOK_RES;
                n_state = S_DONE;
            end
            S_ROOT: begin
                o_op    = grm_pkg::OP_ROOT;
                n_state = S_FETCH;
            end
            S_FETCH: begin
                if (i_stat.slot_end) begin
                    if (i_stat.depth_one) begin
                        n_state = S_DONE;
                    end else begin
                        o_op    = grm_pkg::OP_POP;
                        n_state = S_POP_LOAD;
                    end
                end else begin
                    o_op    = grm_pkg::OP_FETCH;
                    n_state = S_CHILD;
                end
            end
            S_CHILD: begin
                if (i_stat.child_zero) begin
                    if (i_stat.depth_one) begin
                        n_state = S_DONE;
                    end else begin
                        o_op    = grm_pkg::OP_POP;
                        n_state = S_POP_LOAD;
                    end
                end else begin
                    o_op    = grm_pkg::OP_CHILD;
                    n_state = i_stat.child_ok ? S_VISIT : S_FETCH;
                end
            end
            S_VISIT: begin
                o_op    = grm_pkg::OP_VISIT;
                n_state = S_FETCH;
            end
            S_POP_LOAD: begin
                o_op    = grm_pkg::OP_POP_LOAD;
                n_state = S_FETCH;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_op        = grm_pkg::OP_RESULT;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state != S_IDLE))
        else $error("accepted item did not start work");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !$past(r_out_valid)) |-> ($past(r_state) == S_DONE))
        else $error("result raised outside the done state");
`endif

endmodule

// File: design/grm_dpath.sv
`timescale 1ns / 1ps
// Datapath of the graph reachability marker: child table, visited map, walk stack.
module grm_dpath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  grm_pkg::t_dp_op    i_op,
    input  grm_pkg::t_in_item  i_in_item,
    output grm_pkg::t_dp_stat  o_stat,
    output grm_pkg::t_out_item o_out_item
);

    // Memories
    logic [grm_pkg::NODE_W-1:0] r_child_table [grm_pkg::TBL_DEPTH];
    logic                       r_visited_map [grm_pkg::NODE_COUNT];
    grm_pkg::t_stk_entry        r_walk_stack  [grm_pkg::NODE_COUNT];

    logic [grm_pkg::NODE_W-1:0] r_tbl_rd;
    logic                       r_vis_rd;
    grm_pkg::t_stk_entry        r_stk_rd;

    // Working registers
    grm_pkg::t_in_item           r_item;
    grm_pkg::t_out_item          r_out;
    logic [grm_pkg::TBL_AW-1:0]  r_sweep_cnt;
    logic [grm_pkg::NODE_W-1:0]  r_top_node;
    logic [grm_pkg::TSLOT_W-1:0] r_top_slot;
    logic [grm_pkg::DEPTH_W-1:0] r_depth;
    logic [grm_pkg::NODE_W-1:0]  r_child;
    logic [grm_pkg::COUNT_W-1:0] r_count;
    logic                        r_res_vis;

    // Memory ports
    logic                        tbl_we;
    logic [grm_pkg::TBL_AW-1:0]  tbl_waddr;
    logic [grm_pkg::NODE_W-1:0]  tbl_wdata;
    logic [grm_pkg::TBL_AW-1:0]  tbl_raddr;
    logic                        vis_we;
    logic [grm_pkg::VIS_AW-1:0]  vis_waddr;
    logic [grm_pkg::VIS_AW-1:0]  vis_raddr;
    logic                        stk_we;
    logic [grm_pkg::VIS_AW-1:0]  stk_waddr;
    logic [grm_pkg::VIS_AW-1:0]  stk_raddr;

    logic slot_ok;
    logic merge_set;
    logic new_child;
    logic stack_room;
    logic sweep_in_map;

    assign slot_ok      = (32'(r_item.slot_index) < grm_pkg::CHILD_SLOTS);
    assign merge_set    = (r_item.command == grm_pkg::CMD_MERGE) && r_item.merge_bit;
    assign new_child    = !r_vis_rd;
    assign stack_room   = (32'(r_depth) < grm_pkg::NODE_COUNT);
    assign sweep_in_map = (32'(r_sweep_cnt) < grm_pkg::NODE_COUNT);

    assign o_stat.cmd            = r_item.command;
    assign o_stat.node_ok        = (32'(r_item.node_id) < grm_pkg::NODE_COUNT);
    assign o_stat.sweep_all_last = (r_sweep_cnt == grm_pkg::TBL_AW'(grm_pkg::TBL_DEPTH - 1));
    assign o_stat.sweep_vis_last = (r_sweep_cnt == grm_pkg::TBL_AW'(grm_pkg::NODE_COUNT - 1));
    assign o_stat.slot_end       = (r_top_slot == grm_pkg::TSLOT_W'(grm_pkg::CHILD_SLOTS));
    assign o_stat.child_zero     = (r_tbl_rd == '0);
    assign o_stat.child_ok       = (32'(r_tbl_rd) < grm_pkg::NODE_COUNT);
    assign o_stat.depth_one      = (r_depth == grm_pkg::DEPTH_W'(1));

    // Reads run every cycle; stack read looks one below the top register
    assign tbl_raddr = grm_pkg::tbl_addr(r_top_node, r_top_slot);
    assign vis_raddr = (i_op == grm_pkg::OP_CHILD) ? grm_pkg::VIS_AW'(r_tbl_rd)
                                                   : grm_pkg::VIS_AW'(r_item.node_id);
    assign stk_raddr = grm_pkg::VIS_AW'(r_depth - grm_pkg::DEPTH_W'(2));
    assign stk_waddr = grm_pkg::VIS_AW'(r_depth - grm_pkg::DEPTH_W'(1));

    always_comb begin
        tbl_we    = 1'b0;
        tbl_waddr = r_sweep_cnt;
        tbl_wdata = '0;
        vis_we    = 1'b0;
        vis_waddr = grm_pkg::VIS_AW'(r_item.node_id);
        stk_we    = 1'b0;
        unique case (i_op)
            grm_pkg::OP_SWEEP_ALL: begin
                tbl_we    = 1'b1;
                vis_we    = sweep_in_map;
                vis_waddr = grm_pkg::VIS_AW'(r_sweep_cnt);
            end
            grm_pkg::OP_SWEEP_VIS: begin
                vis_we    = 1'b1;
                vis_waddr = grm_pkg::VIS_AW'(r_sweep_cnt);
            end
            grm_pkg::OP_WRITE: begin
                tbl_we    = slot_ok;
                tbl_waddr = grm_pkg::tbl_addr(r_item.node_id,
                                              grm_pkg::TSLOT_W'(r_item.slot_index));
                tbl_wdata = r_item.child_id;
            end
            grm_pkg::OP_LOOK_RES: begin
                vis_we = merge_set;
            end
            grm_pkg::OP_ROOT: begin
                vis_we = new_child;
            end
            grm_pkg::OP_VISIT: begin
                vis_we    = new_child;
                vis_waddr = grm_pkg::VIS_AW'(r_child);
                stk_we    = new_child && stack_room;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_child_table[tbl_waddr] <= tbl_wdata;
        end
        if (vis_we) begin
            r_visited_map[vis_waddr] <= (i_op != grm_pkg::OP_SWEEP_ALL) &&
                                        (i_op != grm_pkg::OP_SWEEP_VIS);
        end
        if (stk_we) begin
            r_walk_stack[stk_waddr] <= '{node: r_top_node, slot: r_top_slot};
        end
        r_tbl_rd <= r_child_table[tbl_raddr];
        r_vis_rd <= r_visited_map[vis_raddr];
        r_stk_rd <= r_walk_stack[stk_raddr];
    end

    // Control counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep_cnt <= '0;
            r_depth     <= '0;
            r_count     <= '0;
        end else begin
            unique case (i_op)
                grm_pkg::OP_SWEEP_ALL: begin
                    r_sweep_cnt <= o_stat.sweep_all_last ? '0
                                                         : r_sweep_cnt + grm_pkg::TBL_AW'(1);
                end
                grm_pkg::OP_SWEEP_VIS: begin
                    r_sweep_cnt <= o_stat.sweep_vis_last ? '0
                                                         : r_sweep_cnt + grm_pkg::TBL_AW'(1);
                end
                grm_pkg::OP_LOAD: begin
                    r_count <= '0;
                end
                grm_pkg::OP_ROOT: begin
                    r_depth <= grm_pkg::DEPTH_W'(1);
                    if (new_child) begin
                        r_count <= grm_pkg::COUNT_W'(1);
                    end
                end
                grm_pkg::OP_VISIT: begin
                    if (new_child) begin
                        if (r_count != '1) begin
                            r_count <= r_count + grm_pkg::COUNT_W'(1);
                        end
                        if (stack_room) begin
                            r_depth <= r_depth + grm_pkg::DEPTH_W'(1);
                        end
                    end
                end
                grm_pkg::OP_POP: begin
                    r_depth <= r_depth - grm_pkg::DEPTH_W'(1);
                end
                default: begin
                end
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        unique case (i_op)
            grm_pkg::OP_LOAD: begin
                r_item    <= i_in_item;
                r_res_vis <= 1'b0;
            end
            grm_pkg::OP_LOOK_RES: begin
                r_res_vis <= r_vis_rd | merge_set;
            end
            grm_pkg::OP_ROOT: begin
                r_res_vis  <= 1'b1;
                r_top_node <= r_item.node_id;
                r_top_slot <= '0;
            end
            grm_pkg::OP_CHILD: begin
                r_top_slot <= r_top_slot + grm_pkg::TSLOT_W'(1);
                r_child    <= r_tbl_rd;
            end
            grm_pkg::OP_VISIT: begin
                if (new_child && stack_room) begin
                    r_top_node <= r_child;
                    r_top_slot <= '0;
                end
            end
            grm_pkg::OP_POP_LOAD: begin
                r_top_node <= r_stk_rd.node;
                r_top_slot <= r_stk_rd.slot;
            end
            grm_pkg::OP_RESULT: begin
                r_out.visited_bit  <= r_res_vis;
                r_out.newly_marked <= r_count;
            end
            default: begin
            end
        endcase
    end

    assign o_out_item = r_out;

`ifndef SYNTHESIS
    a_pop_keeps_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == grm_pkg::OP_POP) |-> (r_depth > grm_pkg::DEPTH_W'(1)))
        else $error("pop would empty the walk stack");

    a_visit_after_child: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == grm_pkg::OP_VISIT) |-> ($past(i_op) == grm_pkg::OP_CHILD))
        else $error("visit without a child lookup");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_count) <= grm_pkg::NODE_COUNT))
        else $error("newly marked count exceeds node count");
`endif

endmodule

// File: design/graph_reachability_marker_top.sv
`timescale 1ns / 1ps
// Top level of the graph reachability marker: depth-first mark engine.
//
//  channel | valid        | stall        | item
//  --------+--------------+--------------+----------------------------------
//  in      | i_in_valid   | o_in_stall   | i_in_item  (command, node, slot..)
//  out     | o_out_valid  | i_out_stall  | o_out_item (visited_bit, count)
//
// Steps: write, read, merge and unused codes are decoded, write the row or
//   look up the bit, then return a result; clear zeroes one map bit a cycle.
// Mark: a root step, then per slot a table read, visited read and update;
//   a pop reloads the top from the stack. One port per memory sets the pace.
// Reset: a pass over all NODE_COUNT * CHILD_SLOTS entries zeroes the child
//   table and visited map; o_in_stall stays high until it ends.
// Stalls: one item at a time; a new item is taken while a result still
//   waits in the output register, and its result waits behind that one.
module graph_reachability_marker_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  grm_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output grm_pkg::t_out_item o_out_item
);

    grm_pkg::t_dp_op   dp_op;
    grm_pkg::t_dp_stat dp_stat;

    // Sequencer: decodes the item and steps the walk
    grm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (dp_stat),
        .o_op        (dp_op)
    );

    // Storage and walk registers
    grm_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op       (dp_op),
        .i_in_item  (i_in_item),
        .o_stat     (dp_stat),
        .o_out_item (o_out_item)
    );

endmodule

// File: sim/graph_reachability_marker_top_test.sv
`timescale 1ns / 1ps
// Self-checking testbench of the graph reachability marker, with its own mark predictor.
//
// Directed rows come first: reads and merges on the extremes of the node range,
// marks of a root with no children and of one already visited, the unused command
// codes, a full child row with a self edge and back edges, and a clear. Rows whose
// result is plain are checked against typed values. All other rows are checked
// against the predictor.
// The random part is made of short episodes: build edges, maybe clear the map,
// mark from a few roots, then probe with reads and merges. Most nodes lie in a
// small window, so the marks walk deep, connected graphs at low cost. Noise items
// with any field values are mixed in.
// Both sides idle at random. One stretch has no idling. Once, the output is held
// off long enough that the block backs up and stalls its input.
module graph_reachability_marker_top_test;

    // Command codes the block does not use: they must change nothing
    localparam logic [grm_pkg::CMD_W-1:0] CMD_RSVD5 = 3'd5;
    localparam logic [grm_pkg::CMD_W-1:0] CMD_RSVD6 = 3'd6;
    localparam logic [grm_pkg::CMD_W-1:0] CMD_RSVD7 = 3'd7;

    localparam int unsigned COUNT_CAP    = 2047;    // newly_marked saturates here
    localparam int unsigned WINDOW       = 64;      // most random nodes fall below this
    localparam int unsigned ITEM_TARGET  = 1150;
    localparam int unsigned HOLD_AT_ITEM = 300;     // the long output hold-off starts here
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned CALM_FIRST   = 500;     // items in [CALM_FIRST, CALM_LAST) run with
    localparam int unsigned CALM_LAST    = 650;     // no idling on either side
    localparam int unsigned DRAIN_CYCLES = 40;

    typedef struct {
        grm_pkg::t_in_item  item;
        bit                 typed;     // result written into the row below
        grm_pkg::t_out_item want;
    } t_plan_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    grm_pkg::t_in_item  i_in_item;
    logic               o_out_valid;
    logic               i_out_stall;
    grm_pkg::t_out_item o_out_item;

    // Predictor state: child table, visited map and the depth-first walk stack
    logic [grm_pkg::NODE_W-1:0] child_rows [grm_pkg::TBL_DEPTH];
    bit                         seen_map   [grm_pkg::NODE_COUNT];
    int unsigned                trail_node [grm_pkg::NODE_COUNT];
    int unsigned                trail_slot [grm_pkg::NODE_COUNT];

    grm_pkg::t_out_item awaited_results[$];
    t_plan_row          directed_plan[$];
    int unsigned        items_sent  = 0;
    int unsigned        bad_results = 0;

    graph_reachability_marker_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Depth-first mark from one root. It returns the number of visited bits it set.
    // A row ends at its first zero child or after its last slot. A root that is
    // already visited still has its children scanned, but it is not counted.
    function automatic int unsigned mark_from(input int unsigned root);
        int unsigned                 added;
        int unsigned                 depth;
        int unsigned                 top_node;
        int unsigned                 top_slot;
        int unsigned                 child;
        logic [grm_pkg::VIS_AW-1:0]  top_at;
        added = 0;
        if (!seen_map[grm_pkg::VIS_AW'(root)]) begin
            seen_map[grm_pkg::VIS_AW'(root)] = 1'b1;
            added++;
        end
        trail_node[0] = root;
        trail_slot[0] = 0;
        depth = 1;
        while (depth > 0) begin
            top_at   = grm_pkg::VIS_AW'(depth - 1);
            top_node = trail_node[top_at];
            top_slot = trail_slot[top_at];
            if (top_slot >= grm_pkg::CHILD_SLOTS) begin
                depth--;
            end else begin
                child = child_rows[grm_pkg::TBL_AW'(top_node * grm_pkg::CHILD_SLOTS + top_slot)];
                if (child == 0) begin
                    depth--;
                end else begin
                    trail_slot[top_at] = top_slot + 1;
                    // children beyond the node range are skipped, and the scan goes on
                    if (child < grm_pkg::NODE_COUNT && !seen_map[grm_pkg::VIS_AW'(child)]) begin
                        seen_map[grm_pkg::VIS_AW'(child)] = 1'b1;
                        if (added < COUNT_CAP) added++;
                        // a full stack drops the push (cannot happen: one push per new bit)
                        if (depth < grm_pkg::NODE_COUNT) begin
                            trail_node[grm_pkg::VIS_AW'(depth)] = child;
                            trail_slot[grm_pkg::VIS_AW'(depth)] = 0;
                            depth++;
                        end
                    end
                end
            end
        end
        return added;
    endfunction

    // Applies one accepted item to the predictor state and returns its result
    function automatic grm_pkg::t_out_item predict_result(input grm_pkg::t_in_item it);
        grm_pkg::t_out_item res;
        int unsigned        added;
        added = 0;
        res   = '0;
        if (it.node_id < grm_pkg::NODE_COUNT) begin
            case (it.command)
                grm_pkg::CMD_WRITE: begin
                    if (it.slot_index < grm_pkg::CHILD_SLOTS)
                        child_rows[grm_pkg::tbl_addr(it.node_id,
                                   grm_pkg::TSLOT_W'(it.slot_index))] = it.child_id;
                end
                grm_pkg::CMD_CLEAR: begin
                    foreach (seen_map[n]) seen_map[n] = 1'b0;
                end
                grm_pkg::CMD_MARK: begin
                    added = mark_from(it.node_id);
                end
                grm_pkg::CMD_MERGE: begin
                    if (it.merge_bit) seen_map[it.node_id] = 1'b1;
                end
                default: begin
                end
            endcase
            res.visited_bit  = seen_map[it.node_id];
            res.newly_marked = grm_pkg::COUNT_W'(added);
        end
        return res;
    endfunction

    function automatic void plan_row(input logic [grm_pkg::CMD_W-1:0] cmd,
                                     input int unsigned node,
                                     input int unsigned slot, input int unsigned child,
                                     input bit mbit, input bit typed, input bit vis,
                                     input int unsigned cnt);
        t_plan_row row;
        row.item.command      = cmd;
        row.item.node_id      = grm_pkg::NODE_W'(node);
        row.item.slot_index   = grm_pkg::SLOT_W'(slot);
        row.item.child_id     = grm_pkg::NODE_W'(child);
        row.item.merge_bit    = mbit;
        row.typed             = typed;
        row.want.visited_bit  = vis;
        row.want.newly_marked = grm_pkg::COUNT_W'(cnt);
        directed_plan.push_back(row);
    endfunction

    // No idling on either side while these items go in
    function automatic bit calm();
        return items_sent >= CALM_FIRST && items_sent < CALM_LAST;
    endfunction

    // Idle length: mostly none, often short, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int unsigned pick_node();
        if ($urandom_range(0, 9) == 0) return $urandom_range(0, grm_pkg::NODE_COUNT - 1);
        return $urandom_range(0, WINDOW - 1);
    endfunction

    // Random item with the given command: children mostly inside the window, some
    // zero to cut lists short, a few over the whole node range
    function automatic grm_pkg::t_in_item make_item(input logic [grm_pkg::CMD_W-1:0] cmd);
        grm_pkg::t_in_item it;
        int unsigned       r;
        r = $urandom_range(0, 99);
        it.command    = cmd;
        it.node_id    = grm_pkg::NODE_W'(pick_node());
        it.slot_index = grm_pkg::SLOT_W'($urandom_range(0, grm_pkg::CHILD_SLOTS - 1));
        if (r < 15)
            it.child_id = '0;
        else if (r < 93)
            it.child_id = grm_pkg::NODE_W'($urandom_range(1, WINDOW - 1));
        else
            it.child_id = grm_pkg::NODE_W'($urandom_range(1, grm_pkg::NODE_COUNT - 1));
        it.merge_bit  = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // Offers one item after a random gap and holds it until the block takes it.
    // Then it queues the result that the item should cause.
    task automatic offer(input grm_pkg::t_in_item it, input bit typed,
                         input grm_pkg::t_out_item want);
        grm_pkg::t_out_item predicted;
        int unsigned        gap;
        gap = calm() ? 0 : pick_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        predicted = predict_result(it);
        awaited_results.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    task automatic note_fault(input string what, input logic [grm_pkg::COUNT_W:0] want,
                              input logic [grm_pkg::COUNT_W:0] got);
        bad_results++;
        if (bad_results <= 10)
            $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, want, got);
    endtask

    // Result side: every accepted result is checked against the oldest expectation
    always @(posedge i_clk) begin
        grm_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (awaited_results.size() == 0) begin
                bad_results++;
                if (bad_results <= 10)
                    $display("%0t: result with none expected: visited_bit %0d newly_marked %0d",
                             $realtime, o_out_item.visited_bit, o_out_item.newly_marked);
            end else begin
                want = awaited_results.pop_front();
                if (o_out_item.visited_bit !== want.visited_bit)
                    note_fault("visited_bit", want.visited_bit, o_out_item.visited_bit);
                if (o_out_item.newly_marked !== want.newly_marked)
                    note_fault("newly_marked", want.newly_marked, o_out_item.newly_marked);
            end
        end
    end

    // Result side stalls: random holds, none in the calm stretch. There is one long
    // hold-off, during which the sender keeps offering items so that the block fills.
    initial begin : out_side
        int unsigned hold;
        bit          held_once;
        held_once = 1'b0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!held_once && items_sent >= HOLD_AT_ITEM) begin
                held_once = 1'b1;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else if (!calm()) begin
                hold = pick_gap();
                if (hold != 0) begin
                    i_out_stall <= 1'b1;
                    repeat (hold) @(posedge i_clk);
                    i_out_stall <= 1'b0;
                end
            end
        end
    end

    // Watchdog. It allows for the clearing pass after reset, the map clears and
    // the marks of the random part, taken many times over.
    initial begin : watchdog
        #50_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : in_side
        grm_pkg::t_in_item it;
        int unsigned       reps;
        foreach (child_rows[a]) child_rows[a] = '0;
        foreach (seen_map[n]) seen_map[n] = 1'b0;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_item  <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows: cmd, node, slot, child, merge_bit, typed, visited_bit, count
        plan_row(grm_pkg::CMD_READ,  0,    0, 0,    1'b0, 1'b1, 1'b0, 0);  // clear after reset
        plan_row(grm_pkg::CMD_READ,  1023, 0, 0,    1'b0, 1'b1, 1'b0, 0);
        plan_row(grm_pkg::CMD_MARK,  5,    0, 0,    1'b0, 1'b1, 1'b1, 1);  // root, no children
        plan_row(grm_pkg::CMD_MARK,  5,    0, 0,    1'b0, 1'b1, 1'b1, 0);  // root already visited
        plan_row(grm_pkg::CMD_MERGE, 1023, 0, 0,    1'b0, 1'b1, 1'b0, 0);  // merging a zero
        plan_row(grm_pkg::CMD_MERGE, 1023, 0, 0,    1'b1, 1'b1, 1'b1, 0);
        plan_row(CMD_RSVD5,          1023, 7, 1023, 1'b1, 1'b1, 1'b1, 0);  // unused codes
        plan_row(CMD_RSVD6,          0,    7, 1023, 1'b1, 1'b1, 1'b0, 0);
        plan_row(CMD_RSVD7,          5,    7, 1023, 1'b1, 1'b1, 1'b1, 0);
        plan_row(grm_pkg::CMD_WRITE, 1023, 7, 1023, 1'b0, 1'b1, 1'b1, 0);  // top slot and child
        plan_row(grm_pkg::CMD_WRITE, 0,    0, 1,    1'b0, 1'b1, 1'b0, 0);
        plan_row(grm_pkg::CMD_WRITE, 1,    0, 2,    1'b0, 1'b0, 1'b0, 0);
        // node 2 gets a full row: a self edge, a back edge and a repeat, so its walk
        // ends after the last slot and not at a zero
        plan_row(grm_pkg::CMD_WRITE, 2,    0, 1,    1'b0, 1'b0, 1'b0, 0);
        plan_row(grm_pkg::CMD_WRITE, 2,    1, 3,    1'b0, 1'b0, 1'b0, 0);
        plan_row(grm_pkg::CMD_WRITE, 2,    2, 1023, 1'b0, 1'b0, 1'b0, 0);
        plan_row(grm_pkg::CMD_WRITE, 2,    3, 4,    1'b0, 1'b0, 1'b0, 0);
        plan_row(grm_pkg::CMD_WRITE, 2,    4, 2,    1'b0, 1'b0, 1'b0, 0);
        plan_row(grm_pkg::CMD_WRITE, 2,    5, 6,    1'b0, 1'b0, 1'b0, 0);
        plan_row(grm_pkg::CMD_WRITE, 2,    6, 7,    1'b0, 1'b0, 1'b0, 0);
        plan_row(grm_pkg::CMD_WRITE, 2,    7, 1,    1'b0, 1'b0, 1'b0, 0);
        plan_row(grm_pkg::CMD_CLEAR, 0,    0, 0,    1'b0, 1'b1, 1'b0, 0);
        plan_row(grm_pkg::CMD_MARK,  0,    0, 0,    1'b0, 1'b0, 1'b0, 0);  // whole small graph
        plan_row(grm_pkg::CMD_MARK,  0,    0, 0,    1'b0, 1'b1, 1'b1, 0);  // all reached already
        plan_row(grm_pkg::CMD_READ,  1023, 0, 0,    1'b0, 1'b1, 1'b1, 0);
        foreach (directed_plan[r])
            offer(directed_plan[r].item, directed_plan[r].typed, directed_plan[r].want);

        // Random episodes: build edges, maybe clear, mark, then probe. Noise items
        // are mixed in.
        while (items_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 99) < 15) begin
                offer(make_item(grm_pkg::CMD_W'($urandom_range(0, 7))), 1'b0, '0);
            end else begin
                reps = $urandom_range(3, 12);
                repeat (reps) offer(make_item(grm_pkg::CMD_WRITE), 1'b0, '0);
                if ($urandom_range(0, 1) == 1) offer(make_item(grm_pkg::CMD_CLEAR), 1'b0, '0);
                reps = $urandom_range(1, 3);
                repeat (reps) offer(make_item(grm_pkg::CMD_MARK), 1'b0, '0);
                reps = $urandom_range(1, 4);
                repeat (reps) begin
                    it = make_item(($urandom_range(0, 1) == 1) ? grm_pkg::CMD_READ
                                                               : grm_pkg::CMD_MERGE);
                    offer(it, 1'b0, '0);
                end
            end
        end
        i_in_valid <= 1'b0;

        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (bad_results == 0 && awaited_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: files.f
design/grm_pkg.sv
design/grm_ctrl.sv
design/grm_dpath.sv
design/graph_reachability_marker_top.sv
sim/graph_reachability_marker_top_test.sv
